/* design/saq_pkg.sv */
// Package for the sorted array priority queue.
// Holds the capacity, widths, status codes and the command struct shared by the cells.
// Depends on nothing.
`default_nettype none
package saq_pkg;
    localparam int CAPACITY = 128;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OUT_CNT_W = 8;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic                    push;
        logic                    pop;
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;
endpackage
`default_nettype wire

/* design/saq_cell.sv */
// One cell of the sorted row: holds a single entry, descending order across the row.
// Depends on saq_pkg for widths and the command struct.
`default_nettype none
module saq_cell (
    input  wire logic                            i_clk,
    input  wire saq_pkg::t_cell_cmd              i_cmd,
    input  wire logic signed [saq_pkg::VAL_W-1:0] i_left_value,
    input  wire logic                            i_left_take,
    input  wire logic signed [saq_pkg::VAL_W-1:0] i_right_value,
    input  wire logic                            i_valid,
    output logic signed [saq_pkg::VAL_W-1:0]     o_value,
    output logic                                 o_take
);
    logic signed [saq_pkg::VAL_W-1:0] r_value;
    logic signed [saq_pkg::VAL_W-1:0] n_value;

    assign o_take  = !i_valid || (i_cmd.value > r_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.push && o_take) begin
            n_value = i_left_take ? i_left_value : i_cmd.value;
        end else if (i_cmd.pop) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end
endmodule
`default_nettype wire

/* design/sorted_array_priority_queue.sv */
// Top level of the sorted array priority queue: a row of saq_cell entries plus count and result.
// Depends on saq_pkg and saq_cell.
//
// Usage:
//   Command channel: an item transfers at a rising edge with i_start high and o_busy low.
//   i_op selects push (0) or pop of the largest entry (1); i_value is the push value.
//   o_busy stays low: a new item can transfer in every cycle.
//   Result channel: one result per item, on o_status, o_popped_value and o_entry_count,
//   marked by o_valid for exactly one cycle, the cycle after the item transfers.
//   Throughput is one item per cycle; every cell updates in parallel, inserting or
//   shifting against its neighbor.
//   Status: success, overflow (push on full, dropped) or underflow (pop on empty,
//   value zero). o_entry_count is the count after the item, modulo 256.
//   Reset (synchronous, active low) empties the queue and clears o_valid; no clearing
//   pass is needed since only entries below the count are read.
//   The receiver cannot stall; each result must be taken in its cycle.
`default_nettype none
module sorted_array_priority_queue (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic                                i_op,
    input  wire logic signed [saq_pkg::VAL_W-1:0]     i_value,
    output logic                                     o_valid,
    output logic [1:0]                               o_status,
    output logic signed [saq_pkg::VAL_W-1:0]         o_popped_value,
    output logic [saq_pkg::OUT_CNT_W-1:0]            o_entry_count
);
    localparam int N = saq_pkg::CAPACITY;

    logic                              w_accept;
    logic                              w_full;
    logic                              w_empty;
    saq_pkg::t_cell_cmd                w_cmd;
    logic signed [saq_pkg::VAL_W-1:0]  w_val  [N];
    logic                              w_take [N];

    logic [saq_pkg::CNT_W-1:0]         r_count;
    logic [saq_pkg::CNT_W-1:0]         n_count;
    logic                              r_valid;
    saq_pkg::t_status                  r_status;
    saq_pkg::t_status                  n_status;
    logic signed [saq_pkg::VAL_W-1:0]  r_popped;
    logic signed [saq_pkg::VAL_W-1:0]  n_popped;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count == saq_pkg::CNT_W'(N));
    assign w_empty  = (r_count == '0);

    assign w_cmd.push  = w_accept && (i_op == saq_pkg::OP_PUSH) && !w_full;
    assign w_cmd.pop   = w_accept && (i_op == saq_pkg::OP_POP) && !w_empty;
    assign w_cmd.value = i_value;

    for (genvar i = 0; i < N; i++) begin : g_cell
        localparam logic [saq_pkg::CNT_W-1:0] IDX = saq_pkg::CNT_W'(i);
        logic signed [saq_pkg::VAL_W-1:0] w_left_value;
        logic                             w_left_take;
        logic signed [saq_pkg::VAL_W-1:0] w_right_value;

        if (i == 0) begin : g_first
            assign w_left_value = '0;
            assign w_left_take  = 1'b0;
        end else begin : g_mid
            assign w_left_value = w_val[i-1];
            assign w_left_take  = w_take[i-1];
        end

        if (i == N - 1) begin : g_last
            assign w_right_value = '0;
        end else begin : g_inner
            assign w_right_value = w_val[i+1];
        end

        saq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_left_value  (w_left_value),
            .i_left_take   (w_left_take),
            .i_right_value (w_right_value),
            .i_valid       (IDX < r_count),
            .o_value       (w_val[i]),
            .o_take        (w_take[i])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = saq_pkg::ST_OK;
        n_popped = '0;
        if (i_op == saq_pkg::OP_PUSH) begin
            if (w_full) begin
                n_status = saq_pkg::ST_OVERFLOW;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = saq_pkg::ST_UNDERFLOW;
            end else begin
                n_count  = r_count - 1'b1;
                n_popped = w_val[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_entry_count  = saq_pkg::OUT_CNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= saq_pkg::CNT_W'(N))
        else $error("count exceeds capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("transfer without result");

    a_underflow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == saq_pkg::ST_UNDERFLOW) |-> (r_count == '0 && r_popped == '0))
        else $error("underflow result inconsistent");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == saq_pkg::ST_OVERFLOW) |-> w_full)
        else $error("overflow while not full");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= saq_pkg::CNT_W'(2)) |-> (w_val[0] >= w_val[1]))
        else $error("row out of order");
endmodule
`default_nettype wire

/* tb/sv/sorted_array_priority_queue_checker.sv */
// Checker for the sorted array priority queue: keeps its own sorted store,
// predicts each result from transferred commands and compares field by field.
// Depends on saq_pkg.
`timescale 1ns / 100ps
module sorted_array_priority_queue_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic                                i_busy,
    input  wire logic                                i_op,
    input  wire logic signed [saq_pkg::VAL_W-1:0]    i_value,
    input  wire logic                                i_valid,
    input  wire logic [1:0]                          i_status,
    input  wire logic signed [saq_pkg::VAL_W-1:0]    i_popped_value,
    input  wire logic [saq_pkg::OUT_CNT_W-1:0]       i_entry_count,
    output int                                       o_fail_count,
    output int                                       o_pending
);
    import saq_pkg::*;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] popped_value;
        logic [OUT_CNT_W-1:0]    entry_count;
    } t_queue_result;

    logic signed [VAL_W-1:0] model_store [CAPACITY];
    int                      model_level;
    t_queue_result           queued_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        model_level  = 0;
    end

    function automatic t_queue_result apply_queue_op(logic op, logic signed [VAL_W-1:0] value);
        t_queue_result res;
        int            pos;
        res.status       = ST_OK;
        res.popped_value = '0;
        if (op == OP_PUSH) begin
            if (model_level >= CAPACITY) begin
                res.status = ST_OVERFLOW;
            end else begin
                pos = 0;
                while (pos < model_level && model_store[pos] <= value) pos++;
                for (int i = model_level; i > pos; i--) model_store[i] = model_store[i-1];
                model_store[pos] = value;
                model_level++;
            end
        end else begin
            if (model_level == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                model_level--;
                res.popped_value = model_store[model_level];
            end
        end
        res.entry_count = model_level[OUT_CNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            model_level = 0;
            queued_results.delete();
        end else begin
            if (i_valid) begin
                if (queued_results.size() == 0) begin
                    report_mismatch("results outstanding", 1, 0);
                end else begin
                    want = queued_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_popped_value !== want.popped_value)
                        report_mismatch("popped_value", i_popped_value, want.popped_value);
                    if (i_entry_count !== want.entry_count)
                        report_mismatch("entry_count", i_entry_count, want.entry_count);
                end
            end
            if (i_start && !i_busy)
                queued_results.push_back(apply_queue_op(i_op, i_value));
        end
        o_pending = queued_results.size();
    end
endmodule

/* tb/sv/sorted_array_priority_queue_test.sv */
// Testbench top for the sorted array priority queue: drives directed and random
// push/pop commands with idle gaps and gives the verdict.
// Depends on saq_pkg, sorted_array_priority_queue and sorted_array_priority_queue_checker.
`timescale 1ns / 100ps
module sorted_array_priority_queue_test;
    import saq_pkg::*;

    localparam int PHASE_ITEMS = 680;
    localparam int CYCLE_LIMIT = 200000;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_start = 1'b0;
    logic                    i_op    = OP_PUSH;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_busy;
    logic                    o_valid;
    logic [1:0]              o_status;
    logic signed [VAL_W-1:0] o_popped_value;
    logic [OUT_CNT_W-1:0]    o_entry_count;
    int                      fail_count;
    int                      pending;
    int                      queue_level = 0;
    int                      cycle_count = 0;

    sorted_array_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count)
    );

    sorted_array_priority_queue_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_popped_value (o_popped_value),
        .i_entry_count  (o_entry_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_array_priority_queue_test failed");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
            3, 4: return $signed($urandom_range(0, 15)) - 32'sd8;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_command(logic op, logic signed [VAL_W-1:0] value, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_op    <= op;
        i_value <= value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (op == OP_PUSH && queue_level < CAPACITY) queue_level++;
        if (op == OP_POP && queue_level > 0) queue_level--;
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(int idle_pct);
        int sent;
        int kind;
        int burst;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                burst = CAPACITY - queue_level + $urandom_range(1, 4);
                repeat (burst) send_command(OP_PUSH, pick_value(), idle_pct);
            end else if (kind < 5) begin
                burst = queue_level + $urandom_range(1, 3);
                repeat (burst) send_command(OP_POP, pick_value(), idle_pct);
            end else begin
                burst = $urandom_range(10, 60);
                repeat (burst)
                    send_command(($urandom_range(0, 99) < 55) ? OP_PUSH : OP_POP,
                                 pick_value(), idle_pct);
            end
            sent += burst;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_command(OP_POP, 32'sh7fffffff, 0);
        send_command(OP_PUSH, 32'sh7fffffff, 0);
        send_command(OP_PUSH, 32'sh80000000, 0);
        send_command(OP_PUSH, 32'sd0, 0);
        send_command(OP_PUSH, -32'sd1, 0);
        send_command(OP_PUSH, 32'sd5, 0);
        send_command(OP_PUSH, 32'sd5, 0);
        send_command(OP_PUSH, -32'sd5, 0);
        send_command(OP_PUSH, 32'sh7fffffff, 0);
        send_command(OP_PUSH, 32'sh80000000, 0);
        send_command(OP_POP, 32'sh80000000, 0);
        send_command(OP_PUSH, 32'sd1, 0);
        repeat (10) send_command(OP_POP, 32'sd0, 0);
        send_command(OP_POP, -32'sd1, 0);

        run_random_phase(0);
        run_random_phase(48);
        run_random_phase(11);

        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("sorted_array_priority_queue_test passed");
        else
            $display("sorted_array_priority_queue_test failed");
        $finish;
    end
endmodule
